// ===== src/crmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ramp interpolator package
// Field widths, arithmetic unit opcodes and control bundle, register indexes.
// ----------------------------------------------------------------------------
package crmp_pkg;

  // Item field widths
  localparam int POS_W     = 17;  // Q16 stop position
  localparam int CHAN_W    = 8;   // one color channel
  localparam int COLOR_W   = 4 * CHAN_W;
  localparam int SLOT_W    = 4;
  localparam int RIDX_W    = 8;   // ramp index
  localparam int FRAC_BITS = 16;

  // Configuration registers
  localparam int RAMP_W     = 9;
  localparam int STOPS_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_SIZE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOPS_IN_USE = 1'd1;

  localparam logic [RAMP_W-1:0]  RAMP_SIZE_RST    = 9'd255;
  localparam logic [STOPS_W-1:0] STOPS_IN_USE_RST = 5'd2;

  // Action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Arithmetic widths: scaled position = pos * ramp_size
  localparam int SCL_W   = POS_W + RAMP_W;    // 26
  localparam int MUL_Y_W = RAMP_W;            // 9, also holds a channel
  localparam int ACC_W   = SCL_W + MUL_Y_W;   // 35
  localparam int SHAMT_W = 3;                 // divider bit position

  // Table entry: position over color
  localparam int ENTRY_W = POS_W + COLOR_W;

  typedef enum logic [1:0] {
    ALU_NOP,
    ALU_MUL,   // acc = x * y + addend
    ALU_MAC,   // acc = acc + x * y
    ALU_DIV    // one restoring division step against x << shamt
  } alu_op_t;

  typedef struct packed {
    alu_op_t              op;
    logic [SCL_W-1:0]     x;
    logic [MUL_Y_W-1:0]   y;
    logic [ACC_W-1:0]     addend;
    logic [SHAMT_W-1:0]   shamt;
  } alu_ctrl_t;

endpackage

// ===== src/crmp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ramp interpolator channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface crmp_in_if;
  import crmp_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [SLOT_W-1:0]   stop_slot;
  logic [POS_W-1:0]    stop_position;
  logic [CHAN_W-1:0]   stop_red;
  logic [CHAN_W-1:0]   stop_green;
  logic [CHAN_W-1:0]   stop_blue;
  logic [CHAN_W-1:0]   stop_alpha;
  logic [RIDX_W-1:0]   ramp_index;

  modport source (
    output valid, action, stop_slot, stop_position,
           stop_red, stop_green, stop_blue, stop_alpha, ramp_index,
    input  ready
  );

  modport sink (
    input  valid, action, stop_slot, stop_position,
           stop_red, stop_green, stop_blue, stop_alpha, ramp_index,
    output ready
  );
endinterface

interface crmp_out_if;
  import crmp_pkg::*;

  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   out_red;
  logic [CHAN_W-1:0]   out_green;
  logic [CHAN_W-1:0]   out_blue;
  logic [CHAN_W-1:0]   out_alpha;
  logic                clamped;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, clamped,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, clamped,
    output ready
  );
endinterface

// ===== src/crmp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module crmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/crmp_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ramp shared arithmetic unit
// One multiplier with accumulator and one restoring divide step.
// ----------------------------------------------------------------------------
module crmp_alu (
  input  logic                        clk,
  input  crmp_pkg::alu_ctrl_t         ctrl,
  output logic [crmp_pkg::ACC_W-1:0]  acc,
  output logic [crmp_pkg::CHAN_W-1:0] quo
);
  import crmp_pkg::*;

  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_nxt;
  logic [CHAN_W-1:0] quo_r;
  logic [CHAN_W-1:0] quo_nxt;
  logic [ACC_W-1:0]  prod;
  logic [ACC_W-1:0]  dsh;
  logic              fits;

  // Shared multiplier and shifted divisor
  assign prod = ACC_W'(ctrl.x) * ACC_W'(ctrl.y);
  assign dsh  = ACC_W'(ctrl.x) << ctrl.shamt;
  assign fits = (acc_r >= dsh);

  // Select the operation
  always_comb begin
    acc_nxt = acc_r;
    quo_nxt = quo_r;
    unique case (ctrl.op)
      ALU_NOP: ;
      ALU_MUL: acc_nxt = prod + ctrl.addend;
      ALU_MAC: acc_nxt = acc_r + prod;
      ALU_DIV: begin
        if (fits) begin
          acc_nxt = acc_r - dsh;
        end
        quo_nxt = {quo_r[CHAN_W-2:0], fits};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
  end

  assign acc = acc_r;
  assign quo = quo_r;

endmodule

// ===== src/color_ramp_interpolator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ramp interpolator
// Piecewise-linear RGBA gradient over a table of color stops.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries load items (action 0: write one stop into a slot) and
//   query items (action 1: interpolate ramp index i). A load writes the
//   table on acceptance and gives no result. A query gives one item on out_ch.
//   The cfg_ port writes ramp_size (index 0) and stops_in_use (index 1);
//   write it only while no query is in flight.
//   A query scans the stops in order through the single table read port
//   (per stop: read, multiply, compare). Index zero and clamped ends are
//   then done; an interpolated color uses the one shared multiply/divide
//   unit for each channel in turn: two multiply-accumulates, eight
//   restoring divide steps and a store of the channel. in_ch.ready is low
//   while a query runs.
//   Reset clears the sequencer and the output valid and loads ramp_size 255
//   and stops_in_use 2; the stop table is not cleared and must be loaded.
//   A stalled receiver holds the result; the block finishes the next query
//   and waits with it until the output register frees up.
// ----------------------------------------------------------------------------
module color_ramp_interpolator_core #(
  parameter int MAX_STOPS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [crmp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crmp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  crmp_in_if.sink                          in_ch,
  crmp_out_if.source                       out_ch
);
  import crmp_pkg::*;

  localparam int IDX_W = $clog2(MAX_STOPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_CMP,
    S_PREP,
    S_CH_A,
    S_CH_B,
    S_DIV,
    S_SAVE,
    S_EMIT
  } state_t;

  state_t               state_r;
  logic [RAMP_W-1:0]    ramp_size_r;
  logic [STOPS_W-1:0]   stops_in_use_r;
  logic [RIDX_W-1:0]    idx_r;
  logic [IDX_W-1:0]     k_r;
  logic [IDX_W-1:0]     s_last_r;
  logic [SCL_W-1:0]     prev_scaled_r;
  logic [COLOR_W-1:0]   prev_col_r;
  logic [COLOR_W-1:0]   cur_col_r;
  logic [SCL_W-1:0]     den_r;
  logic [SCL_W-1:0]     num_r;
  logic [SCL_W-1:0]     dmn_r;
  logic [1:0]           ch_r;
  logic [SHAMT_W-1:0]   cnt_r;
  logic [COLOR_W-1:0]   res_r;
  logic                 clamp_r;
  logic                 out_valid_r;
  logic [COLOR_W-1:0]   out_col_r;
  logic                 out_clamp_r;

  logic                 in_acc;
  logic                 emit_go;
  logic                 load_wr;
  logic [ENTRY_W-1:0]   wr_entry;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [ENTRY_W-1:0]   rd_entry;
  logic [POS_W-1:0]     rd_pos;
  logic [IDX_W-1:0]     s_last;
  logic [SCL_W-1:0]     target;
  logic [SCL_W-1:0]     scaled;
  logic [SCL_W-1:0]     num_c;
  logic [CHAN_W-1:0]    chan_a;
  logic [CHAN_W-1:0]    chan_b;
  alu_ctrl_t            alu_ctrl;
  logic [ACC_W-1:0]     alu_acc;
  logic [CHAN_W-1:0]    alu_quo;

  // Handshake and table write
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign load_wr     = in_acc && (in_ch.action == ACT_LOAD)
                       && (32'(in_ch.stop_slot) < MAX_STOPS);
  assign wr_entry    = {in_ch.stop_position, in_ch.stop_alpha, in_ch.stop_blue,
                        in_ch.stop_green, in_ch.stop_red};

  // Hand the finished result to the output register once it is free
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  // Read the stop at the scan index, or the next one while comparing
  assign rd_en   = (state_r == S_FETCH) || (state_r == S_CMP);
  assign rd_addr = (state_r == S_FETCH) ? k_r : IDX_W'(k_r + 1'b1);
  assign rd_pos  = rd_entry[ENTRY_W-1 -: POS_W];

  crmp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_STOPS)
  ) u_stop_ram (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (IDX_W'(in_ch.stop_slot)),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  // Saturate the stop count into 2..MAX_STOPS, keep the last index
  always_comb begin
    int unsigned cnt;
    cnt = 32'(stops_in_use_r);
    if (cnt < 2) begin
      cnt = 2;
    end else if (cnt > MAX_STOPS) begin
      cnt = MAX_STOPS;
    end
    s_last = IDX_W'(cnt - 1);
  end

  assign target = SCL_W'({idx_r, {FRAC_BITS{1'b0}}});
  assign scaled = alu_acc[SCL_W-1:0];
  assign num_c  = (num_r > den_r) ? den_r : num_r;
  assign chan_a = prev_col_r[{ch_r, 3'b000} +: CHAN_W];
  assign chan_b = cur_col_r[{ch_r, 3'b000} +: CHAN_W];

  // Drive the shared unit from the sequencer state
  always_comb begin
    alu_ctrl = '{op: ALU_NOP, x: '0, y: '0, addend: '0, shamt: '0};
    unique case (state_r)
      S_MUL: begin
        alu_ctrl.op = ALU_MUL;
        alu_ctrl.x  = SCL_W'(rd_pos);
        alu_ctrl.y  = ramp_size_r;
      end
      S_CH_A: begin
        alu_ctrl.op     = ALU_MUL;
        alu_ctrl.x      = dmn_r;
        alu_ctrl.y      = MUL_Y_W'(chan_a);
        alu_ctrl.addend = ACC_W'(den_r >> 1);
      end
      S_CH_B: begin
        alu_ctrl.op = ALU_MAC;
        alu_ctrl.x  = num_r;
        alu_ctrl.y  = MUL_Y_W'(chan_b);
      end
      S_DIV: begin
        alu_ctrl.op    = ALU_DIV;
        alu_ctrl.x     = den_r;
        alu_ctrl.shamt = cnt_r;
      end
      default: ;
    endcase
  end

  crmp_alu u_alu (
    .clk  (clk),
    .ctrl (alu_ctrl),
    .acc  (alu_acc),
    .quo  (alu_quo)
  );

  // Sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      ramp_size_r    <= RAMP_SIZE_RST;
      stops_in_use_r <= STOPS_IN_USE_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RAMP_SIZE:    ramp_size_r    <= cfg_wdata[RAMP_W-1:0];
          CFG_STOPS_IN_USE: stops_in_use_r <= cfg_wdata[STOPS_W-1:0];
          default: ;
        endcase
      end

      // Load a finished result, or drop the current one once taken
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_ch.action == ACT_QUERY)) begin
            idx_r    <= in_ch.ramp_index;
            k_r      <= '0;
            s_last_r <= s_last;
            state_r  <= S_FETCH;
          end
        end
        S_FETCH: state_r <= S_MUL;
        S_MUL: begin
          cur_col_r <= rd_entry[COLOR_W-1:0];
          state_r   <= S_CMP;
        end
        S_CMP: begin
          if (k_r == '0) begin
            if (idx_r == '0) begin
              res_r   <= cur_col_r;
              clamp_r <= 1'b0;
              state_r <= S_EMIT;
            end else if (target < scaled) begin
              // Before the first stop
              res_r   <= cur_col_r;
              clamp_r <= 1'b1;
              state_r <= S_EMIT;
            end else begin
              prev_scaled_r <= scaled;
              prev_col_r    <= cur_col_r;
              k_r           <= IDX_W'(k_r + 1'b1);
              state_r       <= S_MUL;
            end
          end else if (target <= scaled) begin
            if ((scaled <= prev_scaled_r) || (target < prev_scaled_r)) begin
              // Zero-width segment: fraction is zero
              res_r   <= prev_col_r;
              clamp_r <= 1'b0;
              state_r <= S_EMIT;
            end else begin
              den_r   <= scaled - prev_scaled_r;
              num_r   <= target - prev_scaled_r;
              state_r <= S_PREP;
            end
          end else if (k_r == s_last_r) begin
            // Past the last stop
            res_r   <= cur_col_r;
            clamp_r <= 1'b1;
            state_r <= S_EMIT;
          end else begin
            prev_scaled_r <= scaled;
            prev_col_r    <= cur_col_r;
            k_r           <= IDX_W'(k_r + 1'b1);
            state_r       <= S_MUL;
          end
        end
        S_PREP: begin
          num_r   <= num_c;
          dmn_r   <= den_r - num_c;
          ch_r    <= '0;
          clamp_r <= 1'b0;
          state_r <= S_CH_A;
        end
        S_CH_A: state_r <= S_CH_B;
        S_CH_B: begin
          cnt_r   <= '1;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == '0) begin
            state_r <= S_SAVE;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_SAVE: begin
          res_r[{ch_r, 3'b000} +: CHAN_W] <= alu_quo;
          if (ch_r == 2'd3) begin
            state_r <= S_EMIT;
          end else begin
            ch_r    <= ch_r + 1'b1;
            state_r <= S_CH_A;
          end
        end
        S_EMIT: begin
          // Hold until the output register is free
          if (emit_go) begin
            out_col_r   <= res_r;
            out_clamp_r <= clamp_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_red   = out_col_r[0*CHAN_W +: CHAN_W];
  assign out_ch.out_green = out_col_r[1*CHAN_W +: CHAN_W];
  assign out_ch.out_blue  = out_col_r[2*CHAN_W +: CHAN_W];
  assign out_ch.out_alpha = out_col_r[3*CHAN_W +: CHAN_W];
  assign out_ch.clamped   = out_clamp_r;

  // A load item never produces a result
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.action == ACT_LOAD)) |=> !$rose(out_ch.valid))
    else $error("result raised after a load item");

  // The scan never runs past the last stop in use
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (k_r <= s_last_r))
    else $error("stop scan beyond last stop");

  // Division only runs with a nonzero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (den_r != '0))
    else $error("divide step with zero divisor");

  // A query item blocks further input on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.action == ACT_QUERY)) |=> !in_ch.ready)
    else $error("input ready right after a query item");

endmodule

// ===== dv/color_ramp_interpolator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color ramp interpolator testbench
// Loads color stop tables and queries ramp indexes through the valid/ready
// channels. Each query is checked against an in-bench interpolation of the
// mirrored stop table under the current ramp_size and stops_in_use. Sender
// gaps, receiver stalls and two long receiver hold-offs vary the flow.
// ----------------------------------------------------------------------------
module color_ramp_interpolator_core_tb;
  import crmp_pkg::*;

  localparam int NUM_STOPS     = 16;
  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 120;     // outlasts the longest query
  localparam int LONG_HOLD     = 600;
  localparam int TOTAL_ITEMS   = 1050;
  localparam int CYCLE_LIMIT   = 800000;

  typedef struct {
    logic               action;
    logic [SLOT_W-1:0]  slot;
    logic [POS_W-1:0]   pos;
    logic [COLOR_W-1:0] rgba;   // {alpha, blue, green, red}
    logic [RIDX_W-1:0]  idx;
  } ramp_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              clamped;
  } ramp_color_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_RARE,
    RX_PERIODIC
  } rx_style_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  crmp_in_if  in_ch ();
  crmp_out_if out_ch ();

  color_ramp_interpolator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Mirror of the stop table and the registers
  logic [POS_W-1:0]   stop_pos_mirror  [NUM_STOPS];
  logic [COLOR_W-1:0] stop_rgba_mirror [NUM_STOPS];
  logic [RAMP_W-1:0]  ramp_n     = RAMP_SIZE_RST;
  logic [STOPS_W-1:0] stop_count = STOPS_IN_USE_RST;

  ramp_item_t  item_fifo [$];
  ramp_color_t pending_colors [$];
  int          items_queued = 0;
  int          fail_count   = 0;
  int          cycle_count  = 0;

  // Sender state
  ramp_item_t next_item;
  logic       in_taken   = 1'b0;
  int         gap_left   = 0;
  int         burst_left = 0;

  // Receiver state
  rx_style_t rx_style      = RX_OPEN;
  int        rx_style_left = 0;
  int        rx_tick       = 0;
  int        hold_left     = 0;
  int        holds_done    = 0;
  int        holds_wanted  = 0;

  always #CLK_HALF clk = ~clk;

  function automatic ramp_color_t rgba_to_color(input logic [COLOR_W-1:0] rgba,
                                                input logic clamp);
    ramp_color_t col;
    col.red     = rgba[7:0];
    col.green   = rgba[15:8];
    col.blue    = rgba[23:16];
    col.alpha   = rgba[31:24];
    col.clamped = clamp;
    return col;
  endfunction

  // Interpolated color for one ramp index against the mirrored table
  function automatic ramp_color_t predict_color(input logic [RIDX_W-1:0] idx);
    longint unsigned    target, n, lo_scl, hi_scl, num, den, v;
    int                 s, k;
    logic [COLOR_W-1:0] lo_col, hi_col, mix;
    s = stop_count;
    if (s < 2) s = 2;
    if (s > NUM_STOPS) s = NUM_STOPS;
    target = 64'(idx) << FRAC_BITS;
    n      = 64'(ramp_n);
    if (target == 0) return rgba_to_color(stop_rgba_mirror[0], 1'b0);
    if (target < 64'(stop_pos_mirror[0]) * n)
      return rgba_to_color(stop_rgba_mirror[0], 1'b1);
    // first stop at or beyond the target, scanning from stop 1
    k = s;
    for (int j = s - 1; j >= 1; j--) begin
      if (target <= 64'(stop_pos_mirror[j]) * n) k = j;
    end
    if (k >= s) return rgba_to_color(stop_rgba_mirror[s-1], 1'b1);
    lo_scl = 64'(stop_pos_mirror[k-1]) * n;
    hi_scl = 64'(stop_pos_mirror[k]) * n;
    lo_col = stop_rgba_mirror[k-1];
    hi_col = stop_rgba_mirror[k];
    if (hi_scl <= lo_scl || target < lo_scl) return rgba_to_color(lo_col, 1'b0);
    num = target - lo_scl;
    den = hi_scl - lo_scl;
    if (num > den) num = den;
    for (int c = 0; c < 4; c++) begin
      v = (64'(lo_col[8*c +: 8]) * (den - num) + 64'(hi_col[8*c +: 8]) * num
           + den / 2) / den;
      mix[8*c +: 8] = (v > 255) ? 8'hFF : v[7:0];
    end
    return rgba_to_color(mix, 1'b0);
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Drive the next pending item, in bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (item_fifo.size() > 0) begin
        next_item = item_fifo.pop_front();
        in_ch.action        <= next_item.action;
        in_ch.stop_slot     <= next_item.slot;
        in_ch.stop_position <= next_item.pos;
        in_ch.stop_red      <= next_item.rgba[7:0];
        in_ch.stop_green    <= next_item.rgba[15:8];
        in_ch.stop_blue     <= next_item.rgba[23:16];
        in_ch.stop_alpha    <= next_item.rgba[31:24];
        in_ch.ramp_index    <= next_item.idx;
        in_ch.valid         <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: long hold-off on request, otherwise a changing stall style
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (holds_done < holds_wanted) begin
      out_ch.ready <= 1'b0;
      hold_left    <= LONG_HOLD;
      holds_done   <= holds_done + 1;
    end else begin
      if (rx_style_left == 0) begin
        rx_style      <= rx_style_t'($urandom_range(0, 3));
        rx_style_left <= $urandom_range(20, 300);
      end else begin
        rx_style_left <= rx_style_left - 1;
      end
      case (rx_style)
        RX_OPEN:     out_ch.ready <= 1'b1;
        RX_COIN:     out_ch.ready <= $urandom_range(0, 1);
        RX_RARE:     out_ch.ready <= ($urandom_range(0, 7) != 0);
        default:     out_ch.ready <= ((rx_tick % 7) >= 3);
      endcase
    end
  end

  // Track accepted items, update the mirror and check results
  always @(posedge clk) begin
    ramp_color_t exp_col;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (in_ch.action == ACT_LOAD) begin
        stop_pos_mirror[in_ch.stop_slot]  = in_ch.stop_position;
        stop_rgba_mirror[in_ch.stop_slot] = {in_ch.stop_alpha, in_ch.stop_blue,
                                             in_ch.stop_green, in_ch.stop_red};
      end else begin
        exp_col        = predict_color(in_ch.ramp_index);
        pending_colors = {pending_colors, exp_col};
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_colors.size() == 0) begin
        $error("result with no expected color pending");
        fail_count++;
      end else begin
        exp_col = pending_colors.pop_front();
        check_field("out_red",   32'(exp_col.red),     32'(out_ch.out_red));
        check_field("out_green", 32'(exp_col.green),   32'(out_ch.out_green));
        check_field("out_blue",  32'(exp_col.blue),    32'(out_ch.out_blue));
        check_field("out_alpha", 32'(exp_col.alpha),   32'(out_ch.out_alpha));
        check_field("clamped",   32'(exp_col.clamped), 32'(out_ch.clamped));
      end
    end
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[color_ramp_interpolator_core] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int unsigned data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data[CFG_DATA_W-1:0];
    if (index == CFG_RAMP_SIZE) ramp_n = data[RAMP_W-1:0];
    else stop_count = data[STOPS_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_load(input int unsigned slot, input int unsigned pos,
                           input logic [COLOR_W-1:0] rgba);
    ramp_item_t it;
    it.action = ACT_LOAD;
    it.slot   = slot[SLOT_W-1:0];
    it.pos    = pos[POS_W-1:0];
    it.rgba   = rgba;
    it.idx    = RIDX_W'($urandom());
    item_fifo = {item_fifo, it};
    items_queued++;
  endtask

  task automatic push_query(input int unsigned idx);
    ramp_item_t it;
    it.action = ACT_QUERY;
    it.slot   = SLOT_W'($urandom());
    it.pos    = POS_W'($urandom());
    it.rgba   = $urandom();
    it.idx    = idx[RIDX_W-1:0];
    item_fifo = {item_fifo, it};
    items_queued++;
  endtask

  // Rising positions spread so that the used stops span roughly 0..1
  task automatic load_sorted_table(input int s);
    int unsigned p, step_max;
    step_max = 131072 / (s - 1);
    p = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, step_max / 2);
    for (int slot = 0; slot < NUM_STOPS; slot++) begin
      if (slot == s - 1 && $urandom_range(0, 1) == 0) p = 65536;
      push_load(slot, p, $urandom());
      if ($urandom_range(0, 7) != 0) p = p + $urandom_range(0, step_max);
      if (p > 65536) p = 65536;
    end
  endtask

  // Wait until every item is accepted and every result has arrived
  task automatic wait_idle();
    do @(posedge clk);
    while (item_fifo.size() != 0 || in_ch.valid || pending_colors.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          phase_no;
    int          s_eff;
    int          hi_idx;
    int unsigned ramp_pick;
    int unsigned stops_pick;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.action        = ACT_LOAD;
    in_ch.stop_slot     = '0;
    in_ch.stop_position = '0;
    in_ch.stop_red      = '0;
    in_ch.stop_green    = '0;
    in_ch.stop_blue     = '0;
    in_ch.stop_alpha    = '0;
    in_ch.ramp_index    = '0;
    out_ch.ready        = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // Directed: black to white from 1/8 to 1, every slot written
    write_reg(CFG_RAMP_SIZE, 255);
    write_reg(CFG_STOPS_IN_USE, 2);
    push_load(0, 8192, 32'h0000_0000);
    push_load(1, 65536, 32'hFFFF_FFFF);
    for (int slot = 2; slot < NUM_STOPS; slot++)
      push_load(slot, $urandom_range(0, 131071), $urandom());
    push_query(0);      // index zero
    push_query(5);      // before the first stop
    push_query(32);     // just past the first stop
    push_query(255);    // exactly on the last stop
    wait_idle();

    // Directed: equal first positions hit exactly, past the last stop, before the first
    write_reg(CFG_RAMP_SIZE, 256);
    write_reg(CFG_STOPS_IN_USE, 3);
    push_load(0, 32768, 32'h11FF_0080);
    push_load(1, 32768, 32'hEE00_FF7F);
    push_load(2, 49152, 32'h5A5A_A5A5);
    push_query(128);
    push_query(200);
    push_query(100);

    // Random phases: new settings, a table, then a run of queries
    phase_no = 0;
    while (items_queued < TOTAL_ITEMS) begin
      wait_idle();
      phase_no++;
      if (phase_no == 2 || phase_no == 9) holds_wanted = holds_wanted + 1;

      case ($urandom_range(0, 11))
        0:       ramp_pick = 0;
        1:       ramp_pick = 1;
        2:       ramp_pick = 511;
        3:       ramp_pick = 2;
        4:       ramp_pick = 256;
        default: ramp_pick = $urandom_range(2, 256);
      endcase
      case ($urandom_range(0, 9))
        0:       stops_pick = 0;
        1:       stops_pick = 1;
        2:       stops_pick = $urandom_range(17, 31);
        3:       stops_pick = 16;
        4:       stops_pick = 2;
        default: stops_pick = $urandom_range(2, 16);
      endcase
      write_reg(CFG_RAMP_SIZE, ramp_pick);
      write_reg(CFG_STOPS_IN_USE, stops_pick);

      s_eff = (stops_pick < 2) ? 2 : ((stops_pick > NUM_STOPS) ? NUM_STOPS : stops_pick);
      hi_idx = (ramp_n == 0) ? 0 : ((ramp_n > 256) ? 255 : ramp_n - 1);

      // Mostly sorted tables; sometimes scattered unsorted loads
      if ($urandom_range(0, 4) != 0) begin
        load_sorted_table(s_eff);
      end else begin
        repeat ($urandom_range(4, 16))
          push_load($urandom_range(0, 15), $urandom_range(0, 131071), $urandom());
      end

      repeat ($urandom_range(15, 50)) begin
        if ($urandom_range(0, 11) == 0)
          push_load($urandom_range(0, 15), $urandom_range(0, 131071), $urandom());
        else if ($urandom_range(0, 6) != 0)
          push_query($urandom_range(0, hi_idx));
        else
          push_query($urandom_range(0, 255));
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("[color_ramp_interpolator_core] OK");
    end else begin
      $display("[color_ramp_interpolator_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== color_ramp_interpolator_core.f =====
src/crmp_pkg.sv
src/crmp_if.sv
src/crmp_ram.sv
src/crmp_alu.sv
src/color_ramp_interpolator_core.sv
dv/color_ramp_interpolator_core_tb.sv
